[rtl/assert_macros.svh]
// assert_macros.svh: assertion shorthands for the LBP code stream unit.
// Expects clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/lbp_pkg.sv]
// lbp_pkg: constants, types and helpers shared by the LBP code stream unit.
// No dependencies.
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = ADDR_W;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = COL_W + 1;
    localparam int FH_W       = ROW_W + 1;
    localparam int CFG_W      = FH_W;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_DIM    = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = Q_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIGNED = 2'd2;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    // one classified pixel on its way to the back end
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [ADDR_W-1:0] addr;
        logic              emit;
        logic              last;
        logic              sgn;
    } pix_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic clearing;
        logic stall;
    } back_stat_t;

    // key whose unsigned order is the selected pixel order
    function automatic logic [PIX_W-1:0] order_key(input logic [PIX_W-1:0] v,
                                                   input logic sgn);
        return v ^ {sgn, {(PIX_W-1){1'b0}}};
    endfunction

endpackage

[rtl/lbp_front.sv]
// lbp_front: configuration registers, raster counters and pixel classification.
// Depends on lbp_pkg.
module lbp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbp_pkg::CFG_W-1:0]       cfg_data,
    input  logic [lbp_pkg::PIX_W-1:0]       pixel_value,
    input  logic                            frame_start,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lbp_pkg::q_stat_t                q_stat,
    input  lbp_pkg::back_stat_t             back_stat,
    output logic                            push,
    output lbp_pkg::pix_entry_t             push_data
);
    import lbp_pkg::*;

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic             sgn_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [FW_W-1:0]  c1;
    logic [FH_W-1:0]  r1;
    logic             row_done;
    logic             frame_done;
    logic [FW_W-1:0]  w_clamp;
    logic [FH_W-1:0]  h_clamp;

    assign in_ready = !q_stat.full && !back_stat.clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        c          = frame_start ? '0 : col_reg;
        r          = frame_start ? '0 : row_reg;
        c1         = {1'b0, c} + FW_W'(1);
        r1         = {1'b0, r} + FH_W'(1);
        row_done   = (c1 >= width_reg);
        frame_done = (r1 >= height_reg);

        push_data.pix  = pixel_value;
        push_data.addr = c;
        push_data.emit = (r >= ROW_W'(2)) && (c >= COL_W'(2));
        push_data.last = row_done && frame_done;
        push_data.sgn  = sgn_reg;

        if (row_done)
        begin
            col_next = '0;
            row_next = frame_done ? '0 : r1[ROW_W-1:0];
        end
        else
        begin
            col_next = c1[COL_W-1:0];
            row_next = r;
        end

        w_clamp = cfg_data[FW_W-1:0];
        if (w_clamp < FW_W'(MIN_DIM))
            w_clamp = FW_W'(MIN_DIM);
        else if (w_clamp > FW_W'(MAX_WIDTH))
            w_clamp = FW_W'(MAX_WIDTH);

        h_clamp = cfg_data[FH_W-1:0];
        if (h_clamp < FH_W'(MIN_DIM))
            h_clamp = FH_W'(MIN_DIM);
        else if (h_clamp > FH_W'(MAX_HEIGHT))
            h_clamp = FH_W'(MAX_HEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_RESET;
            height_reg <= FH_RESET;
            sgn_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= w_clamp;
                CFG_FRAME_HEIGHT: height_reg <= h_clamp;
                CFG_PIXEL_SIGNED: sgn_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/lbp_queue.sv]
// lbp_queue: short FIFO of classified pixels between front and back end.
// Depends on lbp_pkg.
module lbp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lbp_pkg::pix_entry_t  push_data,
    input  logic                 pop,
    output lbp_pkg::pix_entry_t  head,
    output lbp_pkg::q_stat_t     q_stat
);
    import lbp_pkg::*;

    pix_entry_t         slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/lbp_back.sv]
// lbp_back: line store memory, 3x3 window, code compare and output register.
// Depends on lbp_pkg.
module lbp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lbp_pkg::pix_entry_t           head,
    input  lbp_pkg::q_stat_t              q_stat,
    output logic                          pop,
    output lbp_pkg::back_stat_t           back_stat,
    output logic [lbp_pkg::PIX_W-1:0]     pattern_code,
    output logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import lbp_pkg::*;

    // each line store word is {upper row, middle row}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] fwd_reg;
    logic               hit_reg;

    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    pix_entry_t         b_entry_reg;
    logic               b_valid_reg;

    // [0..2] column c-2, [3..5] column c-1; top, middle, bottom
    logic [PIX_W-1:0]   win_reg [6];

    logic               out_valid_reg;
    logic [PIX_W-1:0]   code_reg;
    logic               last_reg;

    logic [PIX_W-1:0]   top_px;
    logic [PIX_W-1:0]   mid_px;
    logic [PIX_W-1:0]   nb [8];
    logic [PIX_W-1:0]   centre_key;
    logic [PIX_W-1:0]   code;
    logic               b_go;
    logic               adv;
    logic               retire;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [2*PIX_W-1:0] mem_wd;

    always_comb
    begin
        top_px = hit_reg ? fwd_reg[2*PIX_W-1:PIX_W] : rd_reg[2*PIX_W-1:PIX_W];
        mid_px = hit_reg ? fwd_reg[PIX_W-1:0]       : rd_reg[PIX_W-1:0];

        nb[0] = win_reg[0];
        nb[1] = win_reg[3];
        nb[2] = top_px;
        nb[3] = mid_px;
        nb[4] = b_entry_reg.pix;
        nb[5] = win_reg[5];
        nb[6] = win_reg[2];
        nb[7] = win_reg[1];
        centre_key = order_key(win_reg[4], b_entry_reg.sgn);
        for (int i = 0; i < 8; i++)
            code[7-i] = (order_key(nb[i], b_entry_reg.sgn) > centre_key);

        b_go   = !b_entry_reg.emit || !out_valid_reg || out_ready;
        adv    = !b_valid_reg || b_go;
        retire = b_valid_reg && adv;
        pop    = adv && !q_stat.empty && !clearing_reg;

        mem_we = clearing_reg || retire;
        mem_wa = clearing_reg ? clr_addr_reg : b_entry_reg.addr;
        mem_wd = clearing_reg ? '0 : {mid_px, b_entry_reg.pix};
    end

    assign back_stat.clearing = clearing_reg;
    assign back_stat.stall    = b_valid_reg && !b_go;
    assign out_valid          = out_valid_reg;
    assign pattern_code       = code_reg;
    assign frame_end          = last_reg;

    // read-first memory; a read of the address retired in the same cycle
    // takes the forwarded word instead
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_wa] <= mem_wd;
        if (pop)
        begin
            rd_reg  <= line_mem[head.addr];
            fwd_reg <= {mid_px, b_entry_reg.pix};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (pop)
            hit_reg <= retire && (b_entry_reg.addr == head.addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MAX_WIDTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            b_entry_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (retire)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= b_entry_reg.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (retire && b_entry_reg.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (retire && b_entry_reg.emit)
        begin
            code_reg <= code;
            last_reg <= b_entry_reg.last;
        end
    end

endmodule

[rtl/lbp_3x3_code_stream_unit.sv]
// lbp_3x3_code_stream_unit: top level of the 3x3 local binary pattern stream.
// Depends on lbp_pkg, assert_macros.svh, lbp_front, lbp_queue, lbp_back.

// Takes one raster pixel per request and returns one 8-bit LBP code for each
// interior pixel once its below-right neighbour has arrived; bit 7 is the
// top-left neighbour, running clockwise to bit 0 on the left. Throughput is
// one pixel per clock while out_ready is high, set by the single read and
// single write per cycle on the 1024-word line store. A pixel passes the
// queue and the back-end entry register, then its code the output register.
// After reset the line store is cleared word by word with in_ready low;
// configuration writes are taken at any time but belong between frames.
`include "assert_macros.svh"

module lbp_3x3_code_stream_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbp_pkg::CFG_W-1:0]       cfg_data,
    input  logic [lbp_pkg::PIX_W-1:0]       pixel_value,
    input  logic                            frame_start,
    input  logic                            in_valid,
    output logic                            in_ready,
    output logic [lbp_pkg::PIX_W-1:0]       pattern_code,
    output logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_ready
);
    import lbp_pkg::*;

    q_stat_t    q_stat;
    back_stat_t back_stat;
    pix_entry_t push_data;
    pix_entry_t head;
    logic       push;
    logic       pop;

    lbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (pixel_value),
        .frame_start (frame_start),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .q_stat      (q_stat),
        .back_stat   (back_stat),
        .push        (push),
        .push_data   (push_data)
    );

    lbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    lbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .back_stat    (back_stat),
        .pattern_code (pattern_code),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    `ASSERT_SAME(a_no_accept_in_clear, back_stat.clearing, !in_ready)
    `ASSERT_SAME(a_no_accept_when_full, q_stat.full, !in_ready)
    `ASSERT_SAME(a_queue_flags, 1'b1, !(q_stat.full && q_stat.empty))
    `ASSERT_SAME(a_stall_only_on_output, back_stat.stall, out_valid && !out_ready)

endmodule
